// ===== hw/rtl/sb5_pkg.sv =====
// Shared constants, types and arithmetic helpers for the 5-tap separable blur.
// No dependencies.
`default_nettype none

package sb5_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int MIN_DIM    = 5;

  localparam int CFG_W      = 11;
  localparam int CFG_IDX_W  = 4;
  localparam int CNT_W      = $clog2(MAX_WIDTH);
  localparam int RCNT_W     = $clog2(MAX_HEIGHT);
  localparam int WDIM_W     = $clog2(MAX_WIDTH + 1);
  localparam int HDIM_W     = $clog2(MAX_HEIGHT + 1);
  localparam int CMPW_W     = (WDIM_W > CFG_W) ? WDIM_W : CFG_W;
  localparam int CMPH_W     = (HDIM_W > CFG_W) ? HDIM_W : CFG_W;

  localparam int CH_W       = 8;
  localparam int NCH        = 3;
  localparam int PIX_W      = CH_W * NCH;
  localparam int HIST_W     = 4 * PIX_W;
  localparam int SUM_W      = 12;
  localparam int SUM3_W     = SUM_W * NCH;
  localparam int PROD_W     = 24;
  localparam int RECIP_SH   = 15;
  localparam logic [PROD_W-1:0] RECIP10 = PROD_W'(3277);

  localparam int OUT_ROW_W  = 10;
  localparam int OUT_COL_W  = 10;

  localparam int OQ_DEPTH   = 16;
  localparam int OQ_AW      = $clog2(OQ_DEPTH);
  localparam int OQ_CW      = $clog2(OQ_DEPTH + 1);
  localparam int NLANE      = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = CFG_IDX_W'(1);

  typedef struct packed {
    logic [OUT_ROW_W-1:0] row;
    logic [OUT_COL_W-1:0] col;
    logic                 last;
  } sb5_tag_t;

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    sb5_tag_t         tag;
  } sb5_res_t;

  // 1,2,4,2,1 weighted sums of three channels
  function automatic logic [SUM3_W-1:0] tap5_sum(input logic [PIX_W-1:0] a,
                                                  input logic [PIX_W-1:0] b,
                                                  input logic [PIX_W-1:0] c,
                                                  input logic [PIX_W-1:0] d,
                                                  input logic [PIX_W-1:0] e);
    logic [SUM3_W-1:0] r;
    r = '0;
    for (int k = 0; k < NCH; k++) begin
      r[SUM_W*k +: SUM_W] = SUM_W'(a[CH_W*k +: CH_W])
                          + (SUM_W'(b[CH_W*k +: CH_W]) << 1)
                          + (SUM_W'(c[CH_W*k +: CH_W]) << 2)
                          + (SUM_W'(d[CH_W*k +: CH_W]) << 1)
                          + SUM_W'(e[CH_W*k +: CH_W]);
    end
    return r;
  endfunction

  // floor(s/10) by reciprocal multiply, exact for s <= 2550
  function automatic logic [PIX_W-1:0] div10_pix(input logic [SUM3_W-1:0] s);
    logic [PROD_W-1:0] p;
    logic [PIX_W-1:0]  r;
    r = '0;
    for (int k = 0; k < NCH; k++) begin
      p = PROD_W'(s[SUM_W*k +: SUM_W]) * RECIP10;
      r[CH_W*k +: CH_W] = p[RECIP_SH +: CH_W];
    end
    return r;
  endfunction

  function automatic logic [WDIM_W-1:0] clamp_w(input logic [CFG_W-1:0] v);
    logic [CMPW_W-1:0] e;
    e = CMPW_W'(v);
    if (e < CMPW_W'(MIN_DIM)) begin
      e = CMPW_W'(MIN_DIM);
    end else if (e > CMPW_W'(MAX_WIDTH)) begin
      e = CMPW_W'(MAX_WIDTH);
    end
    return WDIM_W'(e);
  endfunction

  function automatic logic [HDIM_W-1:0] clamp_h(input logic [CFG_W-1:0] v);
    logic [CMPH_W-1:0] e;
    e = CMPH_W'(v);
    if (e < CMPH_W'(MIN_DIM)) begin
      e = CMPH_W'(MIN_DIM);
    end else if (e > CMPH_W'(MAX_HEIGHT)) begin
      e = CMPH_W'(MAX_HEIGHT);
    end
    return HDIM_W'(e);
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/sb5_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module sb5_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/sb5_vlane.sv =====
// One vertical filter lane: 5-tap column sum registered, then divide by 10.
// Depends on sb5_pkg.
`default_nettype none

module sb5_vlane
  import sb5_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              vld,
  input  wire logic [HIST_W-1:0] hist,
  input  wire logic [PIX_W-1:0]  tval,
  input  wire sb5_tag_t          tag,
  output      logic              res_vld,
  output      sb5_res_t          res
);

  logic              vld_r;
  logic [SUM3_W-1:0] vsum_r;
  sb5_tag_t          tag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld;
    end
  end

  // hist: oldest row in the low slot
  always_ff @(posedge clk) begin
    if (vld) begin
      vsum_r <= tap5_sum(hist[0 +: PIX_W], hist[PIX_W +: PIX_W],
                         hist[2*PIX_W +: PIX_W], hist[3*PIX_W +: PIX_W], tval);
      tag_r  <= tag;
    end
  end

  assign res_vld = vld_r;
  assign res.pix = div10_pix(vsum_r);
  assign res.tag = tag_r;

endmodule

`default_nettype wire

// ===== hw/rtl/sb5_merge.sv =====
// Output merge: queues up to three lane results per cycle in order, drains one per
// transfer, and tracks reserved space for items in flight. Depends on sb5_pkg.
`default_nettype none

module sb5_merge
  import sb5_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [1:0]       rsv_n,
  output      logic             room,
  input  wire logic [NLANE-1:0] lane_vld,
  input  wire sb5_res_t         lane_res [NLANE],
  output      logic             out_valid,
  input  wire logic             out_ready,
  output      sb5_res_t         out_res
);

  sb5_res_t         mem_r [OQ_DEPTH];
  logic [OQ_AW-1:0] head_r, tail_r;
  logic [OQ_CW-1:0] cnt_r, cnt_nxt;
  logic [OQ_CW-1:0] res_r, res_nxt;
  logic [OQ_CW-1:0] push_n;
  logic [OQ_AW-1:0] off [NLANE];
  logic             pop;

  always_comb begin
    push_n = '0;
    for (int k = 0; k < NLANE; k++) begin
      off[k] = OQ_AW'(push_n);
      push_n = push_n + OQ_CW'(lane_vld[k]);
    end
  end

  assign pop       = out_valid && out_ready;
  assign out_valid = (cnt_r != '0);
  assign out_res   = mem_r[head_r];
  assign room      = (res_r <= OQ_CW'(OQ_DEPTH - NLANE));
  assign cnt_nxt   = cnt_r + push_n - OQ_CW'(pop);
  assign res_nxt   = res_r + OQ_CW'(rsv_n) - OQ_CW'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
      res_r  <= '0;
    end else begin
      head_r <= head_r + OQ_AW'(pop);
      tail_r <= tail_r + OQ_AW'(push_n);
      cnt_r  <= cnt_nxt;
      res_r  <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NLANE; k++) begin
      if (lane_vld[k]) begin
        mem_r[tail_r + off[k]] <= lane_res[k];
      end
    end
  end

`ifndef ASSERT_OFF
  a_rsv_covers: assert property (@(posedge clk) disable iff (!rst_n)
    res_r >= cnt_r)
    else $error("reserved count below queue occupancy");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (push_n != '0) |-> ((cnt_r + push_n) <= OQ_CW'(OQ_DEPTH)))
    else $error("output queue overflow");

  a_lane_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    (lane_vld[2] || lane_vld[1]) |-> (lane_vld[0] && lane_vld[1]))
    else $error("row-end burst not contiguous");

  a_rsv_bound: assert property (@(posedge clk) disable iff (!rst_n)
    res_r <= OQ_CW'(OQ_DEPTH))
    else $error("reservation exceeds queue depth");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/separable_blur_5tap.sv =====
// Top level of the streaming 5x5 separable blur (weights 1,2,4,2,1 over 10).
// Depends on sb5_pkg, sb5_ram, sb5_vlane and sb5_merge.
//
// Takes one pixel per clock in raster order; the pipeline never stalls internally,
// and in_ready drops only when the 16-entry output queue could not take another
// three results beyond those of items already in flight. A result reaches the output
// queue after the stage-1 registers and a lane's sum register. The last pixel of
// each row yields three results (columns W-3, W-2, W-1), which the queue absorbs
// while columns 2 and 3 of the next row yield none. Column history of the last
// four rows lives in a 1024 x 96 RAM (at most one read and one write per pixel);
// the two rightmost columns keep theirs in registers. There is no clearing pass
// after reset: the first four rows of each frame fill the history before any
// result is computed. A width or height write restarts the frame at row 0, column 0.
`default_nettype none

module separable_blur_5tap
  import sb5_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output      logic                 in_ready,
  input  wire logic [CH_W-1:0]      in_chan0_in,
  input  wire logic [CH_W-1:0]      in_chan1_in,
  input  wire logic [CH_W-1:0]      in_chan2_in,
  output      logic                 out_valid,
  input  wire logic                 out_ready,
  output      logic [CH_W-1:0]      out_chan0_out,
  output      logic [CH_W-1:0]      out_chan1_out,
  output      logic [CH_W-1:0]      out_chan2_out,
  output      logic [OUT_ROW_W-1:0] out_row,
  output      logic [OUT_COL_W-1:0] out_col,
  output      logic                 out_run_last,
  input  wire logic                 cfg_valid,
  output      logic                 cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  logic [CFG_W-1:0]  width_r, height_r;
  logic [CNT_W-1:0]  col_r;
  logic [RCNT_W-1:0] row_r;
  logic [PIX_W-1:0]  win_r [4];
  logic [HIST_W-1:0] hw2_r, hw1_r;

  logic              in_fire, cfg_fire, cfg_hit;
  logic [WDIM_W-1:0] w_dim, xw, tcol0;
  logic [HDIM_W-1:0] h_dim;
  logic              is_end, is_copy, is_mid, is_op, vert, row_end;
  logic [PIX_W-1:0]  cur;
  logic [1:0]        rsv_n;
  logic              room;

  logic              s1_v_r, s1_vert_r, s1_end_r, s1_sum_r;
  logic [SUM3_W-1:0] s1_hsum_r;
  logic [PIX_W-1:0]  s1_cur_r, s1_pw0_r, tval0;
  logic [CNT_W-1:0]  s1_addr_r;
  sb5_tag_t          s1_tag_r [NLANE];
  logic [HIST_W-1:0] ram_rdata;

  logic [NLANE-1:0]  lane_vld;
  sb5_res_t          lane_res [NLANE];
  sb5_res_t          out_res;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign cfg_hit   = (cfg_index == CFG_IMAGE_WIDTH) || (cfg_index == CFG_IMAGE_HEIGHT);
  assign in_ready  = room;
  assign in_fire   = in_valid && in_ready;

  assign cur     = {in_chan2_in, in_chan1_in, in_chan0_in};
  assign w_dim   = clamp_w(width_r);
  assign h_dim   = clamp_h(height_r);
  assign xw      = WDIM_W'(col_r);
  assign is_end  = (xw == w_dim - WDIM_W'(1));
  assign is_copy = !is_end && (col_r < CNT_W'(2));
  assign is_mid  = !is_end && (col_r >= CNT_W'(4));
  assign is_op   = is_end || is_copy || is_mid;
  assign vert    = (row_r >= RCNT_W'(4));
  assign row_end = (HDIM_W'(row_r) == h_dim - HDIM_W'(1));

  always_comb begin
    if (is_end) begin
      tcol0 = w_dim - WDIM_W'(3);
    end else if (is_copy) begin
      tcol0 = xw;
    end else begin
      tcol0 = xw - WDIM_W'(2);
    end
    if (!vert || !is_op) begin
      rsv_n = 2'd0;
    end else if (is_end) begin
      rsv_n = 2'd3;
    end else begin
      rsv_n = 2'd1;
    end
  end

  // configuration and frame counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= CFG_W'(640);
      height_r <= CFG_W'(480);
      col_r    <= '0;
      row_r    <= '0;
    end else if (cfg_fire) begin
      if (cfg_index == CFG_IMAGE_WIDTH) begin
        width_r <= cfg_data;
      end
      if (cfg_index == CFG_IMAGE_HEIGHT) begin
        height_r <= cfg_data;
      end
      if (cfg_hit) begin
        col_r <= '0;
        row_r <= '0;
      end
    end else if (in_fire) begin
      if (is_end) begin
        col_r <= '0;
        row_r <= row_end ? '0 : row_r + RCNT_W'(1);
      end else begin
        col_r <= col_r + CNT_W'(1);
      end
    end
  end

  // stage 1 control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= in_fire && is_op;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      win_r[3]  <= win_r[2];
      win_r[2]  <= win_r[1];
      win_r[1]  <= win_r[0];
      win_r[0]  <= cur;
      s1_vert_r <= vert;
      s1_end_r  <= is_end;
      s1_sum_r  <= !is_copy;
      s1_hsum_r <= tap5_sum(win_r[3], win_r[2], win_r[1], win_r[0], cur);
      s1_cur_r  <= cur;
      s1_pw0_r  <= win_r[0];
      s1_addr_r <= CNT_W'(tcol0);
      s1_tag_r[0].row  <= OUT_ROW_W'(row_r - RCNT_W'(2));
      s1_tag_r[0].col  <= OUT_COL_W'(tcol0);
      s1_tag_r[0].last <= !is_end;
      s1_tag_r[1].row  <= OUT_ROW_W'(row_r - RCNT_W'(2));
      s1_tag_r[1].col  <= OUT_COL_W'(w_dim - WDIM_W'(2));
      s1_tag_r[1].last <= 1'b0;
      s1_tag_r[2].row  <= OUT_ROW_W'(row_r - RCNT_W'(2));
      s1_tag_r[2].col  <= OUT_COL_W'(w_dim - WDIM_W'(1));
      s1_tag_r[2].last <= 1'b1;
    end
  end

  assign tval0 = s1_sum_r ? div10_pix(s1_hsum_r) : s1_cur_r;

  // rightmost two columns keep their row history in registers
  always_ff @(posedge clk) begin
    if (s1_v_r && s1_end_r) begin
      hw2_r <= {s1_pw0_r, hw2_r[HIST_W-1:PIX_W]};
      hw1_r <= {s1_cur_r, hw1_r[HIST_W-1:PIX_W]};
    end
  end

  sb5_ram #(
    .WIDTH (HIST_W),
    .DEPTH (MAX_WIDTH)
  ) u_hist_ram (
    .clk   (clk),
    .we    (s1_v_r),
    .waddr (s1_addr_r),
    .wdata ({tval0, ram_rdata[HIST_W-1:PIX_W]}),
    .re    (in_fire && is_op),
    .raddr (CNT_W'(tcol0)),
    .rdata (ram_rdata)
  );

  sb5_vlane u_lane0 (
    .clk     (clk),
    .rst_n   (rst_n),
    .vld     (s1_v_r && s1_vert_r),
    .hist    (ram_rdata),
    .tval    (tval0),
    .tag     (s1_tag_r[0]),
    .res_vld (lane_vld[0]),
    .res     (lane_res[0])
  );

  sb5_vlane u_lane1 (
    .clk     (clk),
    .rst_n   (rst_n),
    .vld     (s1_v_r && s1_vert_r && s1_end_r),
    .hist    (hw2_r),
    .tval    (s1_pw0_r),
    .tag     (s1_tag_r[1]),
    .res_vld (lane_vld[1]),
    .res     (lane_res[1])
  );

  sb5_vlane u_lane2 (
    .clk     (clk),
    .rst_n   (rst_n),
    .vld     (s1_v_r && s1_vert_r && s1_end_r),
    .hist    (hw1_r),
    .tval    (s1_cur_r),
    .tag     (s1_tag_r[2]),
    .res_vld (lane_vld[2]),
    .res     (lane_res[2])
  );

  sb5_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsv_n     (in_fire ? rsv_n : 2'd0),
    .room      (room),
    .lane_vld  (lane_vld),
    .lane_res  (lane_res),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_chan0_out = out_res.pix[0 +: CH_W];
  assign out_chan1_out = out_res.pix[CH_W +: CH_W];
  assign out_chan2_out = out_res.pix[2*CH_W +: CH_W];
  assign out_row       = out_res.tag.row;
  assign out_col       = out_res.tag.col;
  assign out_run_last  = out_res.tag.last;

endmodule

`default_nettype wire

// ===== dv/separable_blur_5tap_checker.sv =====
// Checker for separable_blur_5tap: follows the config, pixel and result transfers,
// predicts each blurred pixel and compares it against the result stream.
// Depends on sb5_pkg for sizes and register indexes.
module separable_blur_5tap_checker
  import sb5_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic [CH_W-1:0]      in_chan0_in,
  input  logic [CH_W-1:0]      in_chan1_in,
  input  logic [CH_W-1:0]      in_chan2_in,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic [CH_W-1:0]      out_chan0_out,
  input  logic [CH_W-1:0]      out_chan1_out,
  input  logic [CH_W-1:0]      out_chan2_out,
  input  logic [OUT_ROW_W-1:0] out_row,
  input  logic [OUT_COL_W-1:0] out_col,
  input  logic                 out_run_last,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output int                   fail_count,
  output int                   outstanding,
  output int                   results_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [CH_W-1:0]      c0;
    logic [CH_W-1:0]      c1;
    logic [CH_W-1:0]      c2;
    logic [OUT_ROW_W-1:0] row;
    logic [OUT_COL_W-1:0] col;
    logic                 last;
  } blur_result_t;

  logic [CFG_W-1:0] frame_width;
  logic [CFG_W-1:0] frame_height;
  logic [PIX_W-1:0] hblur_rows [0:3][0:MAX_WIDTH-1];
  logic [PIX_W-1:0] recent_px [0:3];
  int unsigned      next_col;
  int unsigned      next_row;
  blur_result_t     blurred_due [$];

  function automatic int unsigned fit_size(input logic [CFG_W-1:0] v, input int unsigned hi);
    if (v < MIN_DIM) begin
      return MIN_DIM;
    end
    if (v > hi) begin
      return hi;
    end
    return v;
  endfunction

  // 1,2,4,2,1 weighting over 10, floored, per channel
  function automatic logic [PIX_W-1:0] weigh5(input logic [PIX_W-1:0] a, b, c, d, e);
    logic [PIX_W-1:0] r;
    int unsigned      s;
    int               k;
    r = '0;
    for (k = 0; k < NCH; k++) begin
      s = a[CH_W*k +: CH_W] + 2 * b[CH_W*k +: CH_W] + 4 * c[CH_W*k +: CH_W]
        + 2 * d[CH_W*k +: CH_W] + e[CH_W*k +: CH_W];
      r[CH_W*k +: CH_W] = CH_W'(s / 10);
    end
    return r;
  endfunction

  task automatic take_pixel(input logic [PIX_W-1:0] cur);
    int unsigned      w, h, x, y, nh, made, i;
    int unsigned      hcol [0:2];
    logic [PIX_W-1:0] hval [0:2];
    logic [PIX_W-1:0] v;
    blur_result_t     staged [0:2];
    w = fit_size(frame_width, MAX_WIDTH);
    h = fit_size(frame_height, MAX_HEIGHT);
    x = (next_col >= w) ? w - 1 : next_col;
    y = (next_row >= h) ? h - 1 : next_row;
    nh = 0;
    made = 0;
    if (x == w - 1) begin
      hcol[0] = w - 3;
      hval[0] = weigh5(recent_px[3], recent_px[2], recent_px[1], recent_px[0], cur);
      hcol[1] = w - 2;
      hval[1] = recent_px[0];
      hcol[2] = w - 1;
      hval[2] = cur;
      nh = 3;
    end else if (x < 2) begin
      hcol[0] = x;
      hval[0] = cur;
      nh = 1;
    end else if (x >= 4) begin
      hcol[0] = x - 2;
      hval[0] = weigh5(recent_px[3], recent_px[2], recent_px[1], recent_px[0], cur);
      nh = 1;
    end
    recent_px[3] = recent_px[2];
    recent_px[2] = recent_px[1];
    recent_px[1] = recent_px[0];
    recent_px[0] = cur;
    for (i = 0; i < nh; i++) begin
      if (y >= 4) begin
        v = weigh5(hblur_rows[(y - 4) % 4][hcol[i]], hblur_rows[(y - 3) % 4][hcol[i]],
                   hblur_rows[(y - 2) % 4][hcol[i]], hblur_rows[(y - 1) % 4][hcol[i]],
                   hval[i]);
        staged[made].c0   = v[0 +: CH_W];
        staged[made].c1   = v[CH_W +: CH_W];
        staged[made].c2   = v[2*CH_W +: CH_W];
        staged[made].row  = OUT_ROW_W'(y - 2);
        staged[made].col  = OUT_COL_W'(hcol[i]);
        staged[made].last = 1'b0;
        made++;
      end
      hblur_rows[y % 4][hcol[i]] = hval[i];
    end
    if (made > 0) begin
      staged[made - 1].last = 1'b1;
    end
    for (i = 0; i < made; i++) begin
      blurred_due.insert(blurred_due.size(), staged[i]);
    end
    x++;
    if (x >= w) begin
      x = 0;
      y++;
      if (y >= h) begin
        y = 0;
      end
    end
    next_col = x;
    next_row = y;
  endtask

  task automatic check_field(input string what, input int unsigned want, got,
                             input blur_result_t at, inout int slips);
    if (want != got) begin
      $display("%0t: %s mismatch at row %0d col %0d: expected %0d, actual %0d",
               $time, what, at.row, at.col, want, got);
      slips++;
    end
  endtask

  always @(posedge clk) begin
    int           slips;
    blur_result_t want;
    slips = 0;
    if (!rst_n) begin
      frame_width  = CFG_W'(640);
      frame_height = CFG_W'(480);
      next_col     = 0;
      next_row     = 0;
      blurred_due.delete();
      outstanding <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_IMAGE_WIDTH) begin
          frame_width = cfg_data;
          next_col    = 0;
          next_row    = 0;
        end else if (cfg_index == CFG_IMAGE_HEIGHT) begin
          frame_height = cfg_data;
          next_col     = 0;
          next_row     = 0;
        end
      end
      if (in_valid && in_ready) begin
        take_pixel({in_chan2_in, in_chan1_in, in_chan0_in});
      end
      if (out_valid && out_ready) begin
        if (blurred_due.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual row %0d col %0d",
                   $time, out_row, out_col);
          slips++;
        end else begin
          want = blurred_due.pop_front();
          check_field("chan0", want.c0, out_chan0_out, want, slips);
          check_field("chan1", want.c1, out_chan1_out, want, slips);
          check_field("chan2", want.c2, out_chan2_out, want, slips);
          check_field("row", want.row, out_row, want, slips);
          check_field("col", want.col, out_col, want, slips);
          check_field("run_last", want.last, out_run_last, want, slips);
        end
        results_checked <= results_checked + 1;
      end
      fail_count  <= fail_count + slips;
      outstanding <= blurred_due.size();
    end
  end

endmodule

// ===== dv/separable_blur_5tap_test.sv =====
// Top-level testbench for separable_blur_5tap: clock, reset, pixel and config
// stimulus, receiver back-pressure and verdict. Depends on sb5_pkg, the block
// and separable_blur_5tap_checker.
module separable_blur_5tap_test;
  import sb5_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_HIGH     = 6;
  localparam int CLK_LOW      = 6;
  localparam int RESET_CYCLES = 9;
  localparam int SETTLE       = 8;
  localparam int END_SETTLE   = 16;
  localparam int PARK_CYCLES  = 80;
  localparam int STALL_LIMIT  = 2000;
  localparam int RANDOM_ITEMS = 60;
  localparam logic [CFG_IDX_W-1:0] CFG_TOP_INDEX = '1;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [CH_W-1:0]      in_chan0_in = '0;
  logic [CH_W-1:0]      in_chan1_in = '0;
  logic [CH_W-1:0]      in_chan2_in = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [CH_W-1:0]      out_chan0_out;
  logic [CH_W-1:0]      out_chan1_out;
  logic [CH_W-1:0]      out_chan2_out;
  logic [OUT_ROW_W-1:0] out_row;
  logic [OUT_COL_W-1:0] out_col;
  logic                 out_run_last;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  int fail_count;
  int outstanding;
  int results_checked;
  int park_serial = 0;
  int pixels_sent = 0;
  int sizes_used = 0;
  int idle_run = 0;

  separable_blur_5tap i_dut (.*);

  separable_blur_5tap_checker i_checker (.*);

  always begin
    #(CLK_HIGH) clk = 1'b1;
    #(CLK_LOW) clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        idle_run <= 0;
      end else begin
        idle_run <= idle_run + 1;
      end
      if (idle_run >= STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
        $display("separable_blur_5tap_test: FAIL");
        $finish;
      end
    end
  end

  // receiver: random stall modes, plus a long park on request
  initial begin : receiver
    int stretch, mode, hold_left, park_seen;
    stretch = 0;
    mode = 0;
    hold_left = 0;
    park_seen = 0;
    forever begin
      @(posedge clk);
      if (park_seen != park_serial) begin
        park_seen = park_serial;
        hold_left = PARK_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        if (stretch == 0) begin
          mode = $urandom_range(0, 2);
          stretch = $urandom_range(5, 40);
        end
        stretch--;
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  function automatic logic [CH_W-1:0] rand_chan();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return {CH_W{1'b1}};
      default: return CH_W'($urandom);
    endcase
  endfunction

  task automatic send_pixel(input logic [CH_W-1:0] c0, c1, c2);
    in_valid    <= 1'b1;
    in_chan0_in <= c0;
    in_chan1_in <= c1;
    in_chan2_in <= c2;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pixels_sent++;
  endtask

  task automatic stream_pixels(input int n, input bit gappy);
    int left, burst, gap;
    left = n;
    while (left > 0) begin
      burst = $urandom_range(1, 24);
      if (burst > left) begin
        burst = left;
      end
      repeat (burst) send_pixel(rand_chan(), rand_chan(), rand_chan());
      left -= burst;
      if (gappy && left > 0) begin
        gap = $urandom_range(0, 5);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic reconfigure(input logic [CFG_W-1:0] w, h);
    wait_drained();
    repeat (SETTLE) @(posedge clk);
    write_reg(CFG_IMAGE_WIDTH, w);
    write_reg(CFG_IMAGE_HEIGHT, h);
    cfg_valid <= 1'b0;
    sizes_used++;
  endtask

  // write to an unused index mid-frame; the frame must carry on
  task automatic poke_stray(input logic [CFG_IDX_W-1:0] idx);
    wait_drained();
    repeat (SETTLE) @(posedge clk);
    write_reg(idx, CFG_W'($urandom));
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    int i, phase, n, split, random_items, w, h;
    phase = 0;
    random_items = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // smallest frame: max, min and checkerboard channels
    reconfigure(CFG_W'(MIN_DIM), CFG_W'(MIN_DIM));
    for (i = 0; i < 25; i++) begin
      send_pixel({CH_W{1'b1}}, '0, ((i / 5 + i % 5) % 2 != 0) ? {CH_W{1'b1}} : '0);
    end

    // undersized values saturate to 5; wraps twice, stray write mid-frame
    reconfigure('0, CFG_W'(3));
    stream_pixels(37, 1'b1);
    poke_stray(CFG_TOP_INDEX);
    stream_pixels(13, 1'b1);

    while (random_items < RANDOM_ITEMS || phase < 3) begin
      if (phase == 1) begin
        // three output rows back to back fill the queue during the park
        w = MIN_DIM;
        h = 7;
        n = 40;
      end else begin
        w = $urandom_range(5, 9);
        h = $urandom_range(5, 7);
        n = $urandom_range(15, 30);
      end
      reconfigure(CFG_W'(w), CFG_W'(h));
      if (phase == 1) begin
        park_serial <= park_serial + 1;
        stream_pixels(n, 1'b0);
      end else begin
        split = $urandom_range(5, n - 5);
        stream_pixels(split, $urandom_range(0, 3) != 0);
        if (phase == 2) begin
          wait_drained();
        end else if ($urandom_range(0, 1) != 0) begin
          poke_stray(CFG_IDX_W'($urandom_range(CFG_IMAGE_HEIGHT + 1, CFG_TOP_INDEX)));
        end
        stream_pixels(n - split, 1'b1);
      end
      random_items += n;
      phase++;
    end

    wait_drained();
    repeat (END_SETTLE) @(posedge clk);
    $display("Covered %0d pixel transfers over %0d frame sizes, stray writes,",
             pixels_sent, sizes_used);
    $display("a long receiver park with a full queue and a full drain; %0d results, %0d bad.",
             results_checked, fail_count);
    if (fail_count == 0) begin
      $display("separable_blur_5tap_test: PASS");
    end else begin
      $display("separable_blur_5tap_test: FAIL");
    end
    $finish;
  end

endmodule
